// ===== hdl/srtt_pkg.sv =====
// ----------------------------------------------------------------------------
// srtt_pkg: shared types and constants for the sorted range translation table
// Item and result layouts, table entry layout, status codes and sizing.
// ----------------------------------------------------------------------------
package srtt_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int GPA_W    = 52;
	localparam int LEN_W    = 53;
	localparam int HOST_W   = 48;
	localparam int TOTAL_W  = 58;

	// action codes
	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_HIT    = 2'd0,
		ST_MISS   = 2'd1,
		ST_INSERT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic              action;
		logic [GPA_W-1:0]  address;
		logic [LEN_W-1:0]  length;
		logic [HOST_W-1:0] host_base;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [HOST_W-1:0]  host_address;
		logic [LEN_W-1:0]   span_bytes;
		logic [CNT_W-1:0]   entry_count;
		logic [TOTAL_W-1:0] total_mapped;
	} res_t;

	// one stored range
	typedef struct packed {
		logic [GPA_W-1:0]  start;
		logic [LEN_W-1:0]  length;
		logic [HOST_W-1:0] host_base;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/srtt_ram.sv =====
// ----------------------------------------------------------------------------
// srtt_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/sorted_range_translation_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_range_translation_table_unit: sorted range table with binary search
// Holds up to CAPACITY ranges sorted by start in one entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd and raise start; the item is taken on an edge where busy is
//   low. Exactly one result follows on the result port, marked by done for
//   a single cycle. The receiver cannot stall; it must take the result then.
//   Lookup (action 0): binary search over the entry RAM, each probe a read
//   and then a compare, with at most ceil(log2(count+1)) probes; a miss
//   inside the table adds a read of the next range.
//   Insert (action 1): same search for the sorted slot, then the later
//   entries move up one at a time, each with a read and a write, then the
//   new entry is written. An insert into a full table is answered from
//   the idle state with status full, and busy stays low.
//   The entry RAM has one read port and one write port.
//   Otherwise busy stays high from acceptance until the result cycle; a
//   new item can be taken in the cycle that done is high.
//   Reset clears the entry count and mapped total; RAM contents are left
//   as they are, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_range_translation_table_unit
	import srtt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SRCH  = 8'b0000_0010,
		S_PROBE = 8'b0000_0100,
		S_HIT   = 8'b0000_1000,
		S_GAP   = 8'b0001_0000,
		S_SHRD  = 8'b0010_0000,
		S_SHWR  = 8'b0100_0000,
		S_PUT   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0] total_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic [CNT_W-1:0]   mid_q;
	logic [CNT_W-1:0]   idx_q;
	logic [GPA_W-1:0]   off_q;
	logic [LEN_W-1:0]   len_q;
	logic [HOST_W-1:0]  base_q;
	logic               done_q;
	res_t               result_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	entry_t             ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	entry_t             rd_entry;

	logic [CNT_W:0]     mid_sum;
	logic [CNT_W-1:0]   mid;
	logic [CNT_W-1:0]   idx_dec;
	logic [GPA_W+1:0]   end_addr;
	logic               addr_below;
	logic               addr_past;
	logic [GPA_W-1:0]   probe_off;
	logic [LEN_W-1:0]   avail;
	logic [LEN_W-1:0]   take;
	logic [HOST_W-1:0]  hit_host;
	logic [GPA_W-1:0]   to_next;
	logic [LEN_W-1:0]   gap;
	logic [TOTAL_W:0]   total_sum;
	logic [TOTAL_W-1:0] total_next;

	srtt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	// search midpoint: floor((lo + hi - 1) / 2), only used while lo < hi
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
	assign mid     = mid_sum[CNT_W:1];
	assign idx_dec = idx_q - CNT_W'(1);

	// probe compare against the entry just read
	assign end_addr   = {2'b0, rd_entry.start} + {1'b0, rd_entry.length};
	assign addr_below = cmd_q.address < rd_entry.start;
	assign addr_past  = {2'b0, cmd_q.address} >= end_addr;
	assign probe_off  = cmd_q.address - rd_entry.start;

	// hit result from latched entry fields
	assign avail    = len_q - {1'b0, off_q};
	assign take     = (cmd_q.length < avail) ? cmd_q.length : avail;
	assign hit_host = base_q + off_q[HOST_W-1:0];

	// miss gap to the next range start (start is above the address here)
	assign to_next = rd_entry.start - cmd_q.address;
	assign gap     = ({1'b0, to_next} < cmd_q.length) ? {1'b0, to_next} : cmd_q.length;

	// saturating running total
	assign total_sum  = {1'b0, total_q} + {(TOTAL_W + 1 - LEN_W)'(0), cmd_q.length};
	assign total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

	// RAM port control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mid[ADDR_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = idx_q[ADDR_W-1:0];
		ram_wdata = rd_entry;
		case (state_q)
			S_SRCH: begin
				if (lo_q < hi_q) begin
					ram_re    = 1'b1;
					ram_raddr = mid[ADDR_W-1:0];
				end else if (cmd_q.action == ACT_LOOKUP && lo_q < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = lo_q[ADDR_W-1:0];
				end
			end
			S_SHRD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_dec[ADDR_W-1:0];
			end
			S_SHWR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[ADDR_W-1:0];
				ram_wdata = rd_entry;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q[ADDR_W-1:0];
				ram_wdata = '{start: cmd_q.address, length: cmd_q.length,
					host_base: cmd_q.host_base};
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == S_PROBE) begin
			off_q  <= probe_off;
			len_q  <= rd_entry.length;
			base_q <= rd_entry.host_base;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			total_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						lo_q <= '0;
						hi_q <= count_q;
						if (cmd.action == ACT_INSERT && count_q == CNT_W'(CAPACITY)) begin
							done_q   <= 1'b1;
							result_q <= '{status: ST_FULL, host_address: '0,
								span_bytes: '0, entry_count: count_q,
								total_mapped: total_q};
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_PROBE;
					end else if (cmd_q.action == ACT_LOOKUP) begin
						if (lo_q < count_q) begin
							state_q <= S_GAP;
						end else begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							result_q <= '{status: ST_MISS, host_address: '0,
								span_bytes: cmd_q.length, entry_count: count_q,
								total_mapped: total_q};
						end
					end else begin
						// insert slot found at lo; move up the entries from lo on
						idx_q   <= count_q;
						state_q <= (count_q > lo_q) ? S_SHRD : S_PUT;
					end
				end
				S_PROBE: begin
					state_q <= S_SRCH;
					if (cmd_q.action == ACT_LOOKUP) begin
						if (addr_below) begin
							hi_q <= mid_q;
						end else if (addr_past) begin
							lo_q <= mid_q + CNT_W'(1);
						end else begin
							state_q <= S_HIT;
						end
					end else begin
						// lower bound: new range goes before equal starts
						if (addr_below || cmd_q.address == rd_entry.start) begin
							hi_q <= mid_q;
						end else begin
							lo_q <= mid_q + CNT_W'(1);
						end
					end
				end
				S_HIT: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					result_q <= '{status: ST_HIT, host_address: hit_host,
						span_bytes: take, entry_count: count_q,
						total_mapped: total_q};
				end
				S_GAP: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					result_q <= '{status: ST_MISS, host_address: '0,
						span_bytes: gap, entry_count: count_q,
						total_mapped: total_q};
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					idx_q   <= idx_dec;
					state_q <= (idx_dec > lo_q) ? S_SHRD : S_PUT;
				end
				S_PUT: begin
					count_q  <= count_q + CNT_W'(1);
					total_q  <= total_next;
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					result_q <= '{status: ST_INSERT, host_address: '0,
						span_bytes: '0, entry_count: count_q + CNT_W'(1),
						total_mapped: total_next};
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
